### design/arru_pkg.sv
// ----------------------------------------------------------------------------
// arru_pkg
// Shared types and constants of the axial rotary rotation unit: status codes,
// register indexes, fixed point constants and reciprocals for the series.
// ----------------------------------------------------------------------------
package arru_pkg;

    localparam int DEF_MAX_QUARTER = 32;
    localparam int DEF_MAX_GRID    = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER = 2'd2;

    localparam logic [2:0] ST_ROT   = 3'd0;
    localparam logic [2:0] ST_PASS  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    localparam logic [4:0] RST_PREFIX  = 5'd5;
    localparam logic [6:0] RST_GRID    = 7'd16;
    localparam logic [5:0] RST_QUARTER = 6'd16;

    // pi in Q30
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // exact floor division by d: (v * M) >> K, v < 2^30
    localparam int H_NST    = 6;
    localparam int SIN_NSTP = 5;

    localparam logic [31:0] COS_M [H_NST] = '{
        32'(((64'd1 << 38) + 64'd131) / 64'd132),
        32'(((64'd1 << 37) + 64'd89) / 64'd90),
        32'(((64'd1 << 36) + 64'd55) / 64'd56),
        32'(((64'd1 << 35) + 64'd29) / 64'd30),
        32'(((64'd1 << 34) + 64'd11) / 64'd12),
        32'(((64'd1 << 31) + 64'd1) / 64'd2)
    };
    localparam int COS_K [H_NST] = '{38, 37, 36, 35, 34, 31};

    localparam logic [31:0] SIN_M [SIN_NSTP] = '{
        32'(((64'd1 << 37) + 64'd109) / 64'd110),
        32'(((64'd1 << 37) + 64'd71) / 64'd72),
        32'(((64'd1 << 36) + 64'd41) / 64'd42),
        32'(((64'd1 << 35) + 64'd19) / 64'd20),
        32'(((64'd1 << 33) + 64'd5) / 64'd6)
    };
    localparam int SIN_K [SIN_NSTP] = '{37, 37, 36, 35, 33};

    typedef struct packed {
        logic [2:0]         code;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_side;

endpackage

### design/axial_rope_rotation_unit_core.sv
// Throughput: one transaction per cycle; each stage holds under backpressure.
// Frequency words are read and written at the input transaction edge.
// Reset (i_rst_n low, synchronous) clears stage valids and loads the config
// registers with their reset values; the frequency table is not cleared.
// ----------------------------------------------------------------------------
// axial_rope_rotation_unit_core
// 2D axial rotary position rotation of one (a, b) pair per transaction.
// ----------------------------------------------------------------------------
module axial_rope_rotation_unit_core #(
    parameter int MAX_QUARTER = arru_pkg::DEF_MAX_QUARTER,
    parameter int MAX_GRID    = arru_pkg::DEF_MAX_GRID
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [arru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [12:0]                   i_token_index,
    input  logic [5:0]                    i_pair_index,
    input  logic signed [31:0]            i_value_a,
    input  logic signed [31:0]            i_value_b,
    input  logic [24:0]                   i_freq_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_out_a,
    output logic signed [31:0]            o_out_b,
    output logic [2:0]                    o_status
);
    import arru_pkg::*;

    localparam int QIDX_W   = (MAX_QUARTER > 1) ? $clog2(MAX_QUARTER) : 1;
    localparam int S_ACC    = 0;
    localparam int S_CHK    = 1;
    localparam int S_ROW1   = 2;
    localparam int S_ROW2   = 3;
    localparam int S_POS    = 4;
    localparam int S_MUL    = 5;
    localparam int S_DVD    = 6;
    localparam int S_DIV0   = 7;
    localparam int DIV_NST  = 7;
    localparam int DIV_STEP = 6;
    localparam int DVD_W    = DIV_NST * DIV_STEP;
    localparam int S_PH     = S_DIV0 + DIV_NST;
    localparam int S_XM     = S_PH + 1;
    localparam int S_X      = S_PH + 2;
    localparam int S_XX     = S_PH + 3;
    localparam int S_X2     = S_PH + 4;
    localparam int S_H0     = S_X2 + 1;
    localparam int S_SP     = S_H0 + 3 * H_NST;
    localparam int S_SV     = S_SP + 1;
    localparam int S_SC     = S_SP + 2;
    localparam int S_PRD    = S_SP + 3;
    localparam int S_SUM    = S_SP + 4;
    localparam int S_OUT    = S_SP + 5;
    localparam int NST      = S_OUT + 1;

    function automatic logic [7:0] f_dstep(input logic [6:0] rem, input logic bin,
                                           input logic [6:0] g);
        logic [7:0] t;
        t = {rem, bin};
        if (t >= {1'b0, g}) begin
            return {1'b1, 7'(t - {1'b0, g})};
        end else begin
            return {1'b0, t[6:0]};
        end
    endfunction

    logic [4:0] r_prefix;
    logic [6:0] r_grid;
    logic [5:0] r_quarter;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;
    logic           w_acc;

    t_side r_side [0:S_SUM];
    t_side n_side0;
    t_side n_side1;

    logic [24:0] r_freq_mem [MAX_QUARTER];

    logic [5:0]  w_slot;
    logic        w_ld_bad;
    logic        w_cfg_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix  <= RST_PREFIX;
            r_grid    <= RST_GRID;
            r_quarter <= RST_QUARTER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PREFIX:  r_prefix  <= i_cfg_data[4:0];
                CFG_GRID:    r_grid    <= i_cfg_data[6:0];
                CFG_QUARTER: r_quarter <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[S_ACC];
    assign w_acc   = i_valid && w_en[S_ACC];
    assign o_valid = r_vld[S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[S_ACC]) begin
                r_vld[S_ACC] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---- input stage: classify, table access
    always_comb begin
        w_ld_bad  = {1'b0, i_pair_index} >= 7'(MAX_QUARTER);
        w_cfg_bad = (r_grid == 7'd0) || ({1'b0, r_grid} > 8'(MAX_GRID)) ||
                    (r_quarter == 6'd0) || ({1'b0, r_quarter} > 7'(MAX_QUARTER)) ||
                    ({1'b0, i_pair_index} >= {r_quarter, 1'b0});
        w_slot    = (i_pair_index < r_quarter) ? i_pair_index
                                               : 6'(i_pair_index - r_quarter);
        n_side0.a = i_value_a;
        n_side0.b = i_value_b;
        if (!i_cmd) begin
            n_side0.code = w_ld_bad ? ST_RANGE : ST_LOAD;
        end else if (i_token_index < {8'd0, r_prefix}) begin
            n_side0.code = ST_PASS;
        end else if (w_cfg_bad) begin
            n_side0.code = ST_RANGE;
        end else begin
            n_side0.code = ST_ROT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !i_cmd && !w_ld_bad) begin
            r_freq_mem[i_pair_index[QIDX_W-1:0]] <= i_freq_word;
        end
    end

    logic [24:0] r_f   [S_ACC:S_POS];
    logic [12:0] r_p   [S_ACC:S_ROW1];
    logic        r_col [S_ACC:S_ROW2];

    always_ff @(posedge i_clk) begin
        if (w_en[S_ACC]) begin
            r_side[S_ACC] <= n_side0;
            r_f[S_ACC]    <= r_freq_mem[w_slot[QIDX_W-1:0]];
            r_p[S_ACC]    <= 13'(i_token_index - {8'd0, r_prefix});
            r_col[S_ACC]  <= i_pair_index >= r_quarter;
        end
        if (w_en[S_CHK]) r_side[S_CHK] <= n_side1;
        for (int k = S_ACC + 1; k <= S_POS; k++) begin
            if (w_en[k]) r_f[k] <= r_f[k-1];
        end
        for (int k = S_ACC + 1; k <= S_ROW1; k++) begin
            if (w_en[k]) r_p[k] <= r_p[k-1];
        end
        for (int k = S_ACC + 1; k <= S_ROW2; k++) begin
            if (w_en[k]) r_col[k] <= r_col[k-1];
        end
        for (int k = S_CHK + 1; k <= S_SUM; k++) begin
            if (w_en[k]) r_side[k] <= r_side[k-1];
        end
    end

    // ---- patch range check: p must be below grid^2
    logic [13:0] w_gg;

    always_comb begin
        w_gg    = r_grid * r_grid;
        n_side1 = r_side[S_ACC];
        if (r_side[S_ACC].code == ST_ROT && {1'b0, r_p[S_ACC]} >= w_gg) begin
            n_side1.code = ST_RANGE;
        end
    end

    // ---- row = p div grid, col = p mod grid
    logic [6:0] r_rrem [S_ROW1:S_ROW2];
    logic [6:0] r_rq   [S_ROW1:S_ROW2];
    logic [6:0] n_rrem1, n_rq1, n_rrem2, n_rq2;

    always_comb begin
        logic [7:0] st;
        n_rrem1 = {1'b0, r_p[S_CHK][12:7]};
        n_rq1   = '0;
        for (int i = 6; i >= 3; i--) begin
            st        = f_dstep(n_rrem1, r_p[S_CHK][i], r_grid);
            n_rrem1   = st[6:0];
            n_rq1[i]  = st[7];
        end
        n_rrem2 = r_rrem[S_ROW1];
        n_rq2   = r_rq[S_ROW1];
        for (int i = 2; i >= 0; i--) begin
            st        = f_dstep(n_rrem2, r_p[S_ROW1][i], r_grid);
            n_rrem2   = st[6:0];
            n_rq2[i]  = st[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_ROW1]) begin
            r_rrem[S_ROW1] <= n_rrem1;
            r_rq[S_ROW1]   <= n_rq1;
        end
        if (w_en[S_ROW2]) begin
            r_rrem[S_ROW2] <= n_rrem2;
            r_rq[S_ROW2]   <= n_rq2;
        end
    end

    // ---- n = 2*pos + 1 - grid, sign and magnitude
    logic [6:0]        w_pos;
    logic signed [8:0] w_n;
    logic [6:0]        r_mag;
    logic              r_neg [S_POS:S_PH-1];

    always_comb begin
        w_pos = r_col[S_ROW2] ? r_rrem[S_ROW2] : r_rq[S_ROW2];
        w_n   = signed'({1'b0, w_pos, 1'b1}) - signed'({2'b00, r_grid});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_POS]) begin
            r_neg[S_POS] <= w_n[8];
            r_mag        <= w_n[8] ? 7'(-w_n) : w_n[6:0];
        end
        for (int k = S_POS + 1; k < S_PH; k++) begin
            if (w_en[k]) r_neg[k] <= r_neg[k-1];
        end
    end

    // ---- |n| * f, then round(|n| * f * 256 / grid)
    logic [31:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (w_en[S_MUL]) r_prod <= r_mag * r_f[S_POS];
    end

    logic [6:0]       r_drem [S_DVD:S_PH-1];
    logic [DVD_W-1:0] r_dvd  [S_DVD:S_PH-1];
    logic [31:0]      r_quo  [S_DVD:S_PH-1];

    always_ff @(posedge i_clk) begin
        if (w_en[S_DVD]) begin
            r_drem[S_DVD] <= '0;
            r_quo[S_DVD]  <= '0;
            r_dvd[S_DVD]  <= DVD_W'({r_prod, 8'd0}) + DVD_W'(r_grid >> 1);
        end
    end

    for (genvar gk = S_DIV0; gk < S_PH; gk++) begin : g_div
        logic [6:0]       n_rem;
        logic [DVD_W-1:0] n_dv;
        logic [31:0]      n_q;

        always_comb begin
            logic [7:0] st;
            n_rem = r_drem[gk-1];
            n_dv  = r_dvd[gk-1];
            n_q   = r_quo[gk-1];
            for (int s = 0; s < DIV_STEP; s++) begin
                st    = f_dstep(n_rem, n_dv[DVD_W-1], r_grid);
                n_rem = st[6:0];
                n_q   = {n_q[30:0], st[7]};
                n_dv  = {n_dv[DVD_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[gk]) begin
                r_drem[gk] <= n_rem;
                r_dvd[gk]  <= n_dv;
                r_quo[gk]  <= n_q;
            end
        end
    end

    // ---- phase fold to an eighth of a turn
    logic [31:0] w_ph;
    logic [29:0] w_r;
    logic        w_swap;
    logic [29:0] r_rr;
    logic [1:0]  r_quad [S_PH:S_SV];
    logic        r_swap [S_PH:S_SV];

    always_comb begin
        w_ph   = r_neg[S_PH-1] ? 32'(-r_quo[S_PH-1]) : r_quo[S_PH-1];
        w_r    = w_ph[29:0];
        w_swap = w_r > 30'h2000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_PH]) begin
            r_quad[S_PH] <= w_ph[31:30];
            r_swap[S_PH] <= w_swap;
            r_rr         <= w_swap ? 30'(31'h4000_0000 - {1'b0, w_r}) : w_r;
        end
        for (int k = S_PH + 1; k <= S_SV; k++) begin
            if (w_en[k]) begin
                r_quad[k] <= r_quad[k-1];
                r_swap[k] <= r_swap[k-1];
            end
        end
    end

    // ---- x = r * pi/2 in Q30, x2 = x^2
    logic [61:0] r_xm;
    logic [29:0] r_x  [S_X:S_SP-1];
    logic [59:0] r_xx;
    logic [29:0] r_x2 [S_X2:S_SP-3];

    always_ff @(posedge i_clk) begin
        if (w_en[S_XM]) r_xm <= r_rr * PI_Q30;
        if (w_en[S_X])  r_x[S_X] <= 30'((63'(r_xm) + (63'd1 << 30)) >> 31);
        for (int k = S_X + 1; k < S_SP; k++) begin
            if (w_en[k]) r_x[k] <= r_x[k-1];
        end
        if (w_en[S_XX]) r_xx <= r_x[S_X] * r_x[S_X];
        if (w_en[S_X2]) r_x2[S_X2] <= 30'((61'(r_xx) + (61'd1 << 29)) >> 30);
        for (int k = S_X2 + 1; k <= S_SP - 3; k++) begin
            if (w_en[k]) r_x2[k] <= r_x2[k-1];
        end
    end

    // ---- Horner series, three stages a term
    logic [60:0] r_hpc [H_NST];
    logic [60:0] r_hps [H_NST];
    logic [61:0] r_hmc [H_NST];
    logic [61:0] r_hms [H_NST];
    logic [30:0] r_htc [H_NST];
    logic [30:0] r_hts [H_NST];

    for (genvar gj = 0; gj < H_NST; gj++) begin : g_hor
        localparam int SA = S_H0 + 3 * gj;
        logic [30:0] w_tc_in;
        logic [30:0] w_ts_in;

        if (gj == 0) begin : g_first
            assign w_tc_in = ONE_Q30;
            assign w_ts_in = ONE_Q30;
        end else begin : g_next
            assign w_tc_in = r_htc[gj-1];
            assign w_ts_in = r_hts[gj-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_en[SA]) begin
                r_hpc[gj] <= r_x2[SA-1] * w_tc_in;
            end
            if (w_en[SA+1]) begin
                r_hmc[gj] <= 30'((62'(r_hpc[gj]) + (62'd1 << 29)) >> 30) * COS_M[gj];
            end
            if (w_en[SA+2]) begin
                r_htc[gj] <= ONE_Q30 - 31'(r_hmc[gj] >> COS_K[gj]);
            end
        end

        if (gj < SIN_NSTP) begin : g_sin
            always_ff @(posedge i_clk) begin
                if (w_en[SA]) begin
                    r_hps[gj] <= r_x2[SA-1] * w_ts_in;
                end
                if (w_en[SA+1]) begin
                    r_hms[gj] <= 30'((62'(r_hps[gj]) + (62'd1 << 29)) >> 30) * SIN_M[gj];
                end
                if (w_en[SA+2]) begin
                    r_hts[gj] <= ONE_Q30 - 31'(r_hms[gj] >> SIN_K[gj]);
                end
            end
        end else begin : g_sin_hold
            // sine series is one term shorter; its value rides along
            always_ff @(posedge i_clk) begin
                if (w_en[SA])   r_hps[gj] <= 61'(w_ts_in);
                if (w_en[SA+1]) r_hms[gj] <= 62'(r_hps[gj]);
                if (w_en[SA+2]) r_hts[gj] <= r_hms[gj][30:0];
            end
        end
    end

    // ---- to Q2.16, octant swap, quadrant signs
    logic [60:0]        r_sp;
    logic [16:0]        r_cv [S_SP:S_SV];
    logic [16:0]        r_sv;
    logic [16:0]        w_s0, w_c0;
    logic signed [17:0] w_s, w_c;
    logic signed [17:0] r_s, r_c;

    always_ff @(posedge i_clk) begin
        if (w_en[S_SP]) begin
            r_sp       <= r_x[S_SP-1] * r_hts[H_NST-1];
            r_cv[S_SP] <= 17'((r_htc[H_NST-1] + 31'd8192) >> 14);
        end
        if (w_en[S_SV]) begin
            r_sv       <= 17'((((62'(r_sp) + (62'd1 << 29)) >> 30) + 62'd8192) >> 14);
            r_cv[S_SV] <= r_cv[S_SP];
        end
    end

    always_comb begin
        w_s0 = r_swap[S_SV] ? r_cv[S_SV] : r_sv;
        w_c0 = r_swap[S_SV] ? r_sv : r_cv[S_SV];
        case (r_quad[S_SV])
            2'd0: begin
                w_s = signed'({1'b0, w_s0});
                w_c = signed'({1'b0, w_c0});
            end
            2'd1: begin
                w_s = signed'({1'b0, w_c0});
                w_c = -signed'({1'b0, w_s0});
            end
            2'd2: begin
                w_s = -signed'({1'b0, w_s0});
                w_c = -signed'({1'b0, w_c0});
            end
            default: begin
                w_s = -signed'({1'b0, w_c0});
                w_c = signed'({1'b0, w_s0});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_SC]) begin
            r_s <= w_s;
            r_c <= w_c;
        end
    end

    // ---- rotation
    logic signed [49:0] r_ac, r_bs, r_bc, r_as;
    logic signed [50:0] r_ya, r_yb;

    always_ff @(posedge i_clk) begin
        if (w_en[S_PRD]) begin
            r_ac <= r_side[S_SC].a * r_c;
            r_bs <= r_side[S_SC].b * r_s;
            r_bc <= r_side[S_SC].b * r_c;
            r_as <= r_side[S_SC].a * r_s;
        end
        if (w_en[S_SUM]) begin
            r_ya <= 51'(r_ac) - 51'(r_bs);
            r_yb <= 51'(r_bc) + 51'(r_as);
        end
    end

    // ---- round half up, saturate, select result
    logic signed [34:0] w_ra, w_rb;
    logic               w_sat_a, w_sat_b;
    logic signed [31:0] w_oa, w_ob;

    always_comb begin
        w_ra    = 35'((r_ya + 51'sd32768) >>> 16);
        w_rb    = 35'((r_yb + 51'sd32768) >>> 16);
        w_sat_a = w_ra[34:31] != {4{w_ra[31]}};
        w_sat_b = w_rb[34:31] != {4{w_rb[31]}};
        w_oa    = w_sat_a ? (w_ra[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_ra[31:0];
        w_ob    = w_sat_b ? (w_rb[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_rb[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            case (r_side[S_SUM].code)
                ST_ROT: begin
                    o_out_a  <= w_oa;
                    o_out_b  <= w_ob;
                    o_status <= (w_sat_a || w_sat_b) ? ST_SAT : ST_ROT;
                end
                ST_PASS: begin
                    o_out_a  <= r_side[S_SUM].a;
                    o_out_b  <= r_side[S_SUM].b;
                    o_status <= ST_PASS;
                end
                default: begin
                    o_out_a  <= '0;
                    o_out_b  <= '0;
                    o_status <= r_side[S_SUM].code;
                end
            endcase
        end
    end

endmodule

### sim/tb_axial_rope_rotation_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axial_rope_rotation_unit_core
// Self-checking bench for the axial rotary rotation unit. Frequency slots are
// loaded first, then a short directed table runs, then random phases under
// several register settings. Each untyped transaction is scored against an
// in-bench fixed point rotation model, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_axial_rope_rotation_unit_core;
    import arru_pkg::*;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ROT  = 1'b1;
    localparam int   NSLOT    = DEF_MAX_QUARTER;
    localparam int   LIMIT    = 400000;
    localparam int   DRAIN    = 60;

    typedef struct packed {
        logic               cmd;
        logic [12:0]        tok;
        logic [5:0]         pair;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [24:0]        fw;
    } rope_item_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [2:0]         st;
    } rope_res_t;

    typedef struct packed {
        rope_item_t it;
        logic       typed;
        rope_res_t  res;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_cmd = 1'b0;
    logic [12:0] i_token_index = '0;
    logic [5:0] i_pair_index = '0;
    logic signed [31:0] i_value_a = '0;
    logic signed [31:0] i_value_b = '0;
    logic [24:0] i_freq_word = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_out_a;
    logic signed [31:0] o_out_b;
    logic [2:0] o_status;

    axial_rope_rotation_unit_core dut (.*);

    always #1 i_clk = ~i_clk;

    logic [24:0] freq_mem [NSLOT];
    logic [4:0]  m_prefix;
    logic [6:0]  m_grid;
    logic [5:0]  m_quarter;
    rope_res_t   pending_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;
    bit          started = 1'b0;

    function automatic longint round_sat16(longint v, ref bit sat);
        longint r;
        r = ((v + (longint'(1) << 50) + 32768) >>> 16) - (longint'(1) << 34);
        if (r > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (r < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic void phase_sincos(logic [31:0] ph, output longint s, output longint c);
        logic [63:0] r, x, x2, ts, tc, sv, cv, tmp;
        logic [63:0] sdiv [5];
        logic [63:0] cdiv [6];
        bit swap;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        r = {34'd0, ph[29:0]};
        swap = r > 64'h2000_0000;
        if (swap) r = 64'h4000_0000 - r;
        x  = (r * 64'd3373259426 + (64'd1 << 30)) >> 31;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        ts = 64'd1 << 30;
        tc = 64'd1 << 30;
        for (int i = 0; i < 5; i++)
            ts = (64'd1 << 30) - (((x2 * ts + (64'd1 << 29)) >> 30) / sdiv[i]);
        for (int i = 0; i < 6; i++)
            tc = (64'd1 << 30) - (((x2 * tc + (64'd1 << 29)) >> 30) / cdiv[i]);
        sv = (((x * ts + (64'd1 << 29)) >> 30) + 64'd8192) >> 14;
        cv = (tc + 64'd8192) >> 14;
        if (swap) begin
            tmp = sv;
            sv = cv;
            cv = tmp;
        end
        case (ph[31:30])
            2'd0: begin s = sv;  c = cv;  end
            2'd1: begin s = cv;  c = -longint'(cv) + longint'(cv) - longint'(sv); end
            2'd2: begin s = -longint'(sv); c = -longint'(cv); end
            default: begin s = -longint'(cv); c = sv; end
        endcase
    endfunction

    function automatic rope_res_t rotate_pair(rope_item_t it);
        rope_res_t res;
        int p, row, col, pos, slot;
        longint n, prod, mag, q, s, c, ra, rb;
        logic [31:0] ph;
        bit sat;
        res = '0;
        sat = 1'b0;
        if (it.cmd == CMD_LOAD) begin
            if (it.pair >= NSLOT) res.st = ST_RANGE;
            else begin
                freq_mem[it.pair] = it.fw;
                res.st = ST_LOAD;
            end
            return res;
        end
        if (it.tok < m_prefix) begin
            res.a = it.a;
            res.b = it.b;
            res.st = ST_PASS;
            return res;
        end
        if (m_grid == 0 || m_grid > DEF_MAX_GRID || m_quarter == 0 ||
            m_quarter > DEF_MAX_QUARTER || it.pair >= 2 * m_quarter) begin
            res.st = ST_RANGE;
            return res;
        end
        p = it.tok - m_prefix;
        row = p / m_grid;
        col = p % m_grid;
        if (row >= m_grid) begin
            res.st = ST_RANGE;
            return res;
        end
        if (it.pair < m_quarter) begin
            pos = row;
            slot = it.pair;
        end else begin
            pos = col;
            slot = it.pair - m_quarter;
        end
        n = 2 * longint'(pos) + 1 - longint'(m_grid);
        prod = n * longint'(freq_mem[slot % NSLOT]) * 256;
        mag = prod < 0 ? -prod : prod;
        q = (mag + m_grid / 2) / m_grid;
        ph = prod < 0 ? 32'(-q) : 32'(q);
        phase_sincos(ph, s, c);
        ra = round_sat16(longint'(it.a) * c - longint'(it.b) * s, sat);
        rb = round_sat16(longint'(it.b) * c + longint'(it.a) * s, sat);
        res.a = ra[31:0];
        res.b = rb[31:0];
        res.st = sat ? ST_SAT : ST_ROT;
        return res;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_PREFIX:  m_prefix = val[4:0];
            CFG_GRID:    m_grid = val[6:0];
            CFG_QUARTER: m_quarter = val[5:0];
            default: ;
        endcase
    endtask

    task automatic send_item(rope_item_t it, bit typed, rope_res_t typed_res);
        rope_res_t pr;
        while (idle_en && $urandom_range(0, 99) < 20) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_cmd = it.cmd;
        i_token_index = it.tok;
        i_pair_index = it.pair;
        i_value_a = it.a;
        i_value_b = it.b;
        i_freq_word = it.fw;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pr = rotate_pair(it);
        pending_q.push_back(typed ? typed_res : pr);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 131072)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic rope_item_t rand_item();
        rope_item_t it;
        int span, pmax;
        it.cmd = CMD_ROT;
        it.a = rand_value();
        it.b = rand_value();
        it.fw = 25'($urandom_range(0, 16777216));
        span = int'(m_grid) * int'(m_grid);
        pmax = 2 * int'(m_quarter) - 1;
        case ($urandom_range(0, 19))
            0, 1: begin
                it.cmd = CMD_LOAD;
                it.pair = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 31));
                it.tok = 13'($urandom);
            end
            2: begin
                it.tok = 13'($urandom);
                it.pair = 6'($urandom);
            end
            3: begin
                it.tok = 13'($urandom_range(0, 31));
                it.pair = 6'($urandom);
            end
            default: begin
                it.tok = 13'(int'(m_prefix) + $urandom_range(0, span > 0 ? span - 1 : 0));
                it.pair = 6'($urandom_range(0, pmax > 0 ? pmax : 0));
            end
        endcase
        return it;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("axial_rope_rotation_unit_core: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rope_res_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction a=%h b=%h st=%0d",
                             o_out_a, o_out_b, o_status);
            end else begin
                e = pending_q.pop_front();
                if (e.a !== o_out_a || e.b !== o_out_b || e.st !== o_status) begin
                    errors++;
                    if (errors <= 10)
                        $display("exp a=%h b=%h st=%0d got a=%h b=%h st=%0d",
                                 e.a, e.b, e.st, o_out_a, o_out_b, o_status);
                end
            end
        end
    end

    initial begin
        @(negedge i_clk);
        while (!started) @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_ready = !idle_en || $urandom_range(0, 99) >= 20;
            @(negedge i_clk);
        end
    end

    initial begin
        dir_row_t   dir [$];
        rope_item_t it;
        rope_res_t  nores;
        logic [6:0] cfg_set [10][3];
        int         nitems;
        nores = '0;
        m_prefix = RST_PREFIX;
        m_grid = RST_GRID;
        m_quarter = RST_QUARTER;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        started = 1'b1;
        @(negedge i_clk);

        for (int s = 0; s < NSLOT; s++) begin
            it = '0;
            it.cmd = CMD_LOAD;
            it.pair = 6'(s);
            it.fw = (s == 0) ? 25'd16777216 : (s == 1) ? 25'd0 : 25'($urandom_range(0, 16777216));
            send_item(it, 1'b0, nores);
        end

        dir.push_back('{'{CMD_ROT, 13'd0, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 25'd0}, 1'b1,
                        '{32'h8000_0000, 32'h7FFF_FFFF, ST_PASS}});
        dir.push_back('{'{CMD_ROT, 13'd4, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 25'h1FF_FFFF},
                        1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, ST_PASS}});
        dir.push_back('{'{CMD_LOAD, 13'd8191, 6'd32, 32'h1, 32'h1, 25'd5}, 1'b1,
                        '{32'd0, 32'd0, ST_RANGE}});
        dir.push_back('{'{CMD_LOAD, 13'd0, 6'd63, 32'h0, 32'h0, 25'd5}, 1'b1,
                        '{32'd0, 32'd0, ST_RANGE}});
        dir.push_back('{'{CMD_LOAD, 13'd0, 6'd20, 32'hFFFF_FFFF, 32'h0, 25'd16777216}, 1'b1,
                        '{32'd0, 32'd0, ST_LOAD}});
        dir.push_back('{'{CMD_LOAD, 13'd0, 6'd31, 32'h0, 32'h0, 25'h0AA_AAAA}, 1'b1,
                        '{32'd0, 32'd0, ST_LOAD}});
        dir.push_back('{'{CMD_ROT, 13'd5, 6'd32, 32'h1, 32'h1, 25'd0}, 1'b1,
                        '{32'd0, 32'd0, ST_RANGE}});
        dir.push_back('{'{CMD_ROT, 13'd100, 6'd63, 32'h1, 32'h1, 25'd0}, 1'b1,
                        '{32'd0, 32'd0, ST_RANGE}});
        dir.push_back('{'{CMD_ROT, 13'd261, 6'd0, 32'h1, 32'h1, 25'd0}, 1'b1,
                        '{32'd0, 32'd0, ST_RANGE}});
        dir.push_back('{'{CMD_ROT, 13'd8191, 6'd5, 32'h1, 32'h1, 25'd0}, 1'b1,
                        '{32'd0, 32'd0, ST_RANGE}});
        dir.push_back('{'{CMD_ROT, 13'd5, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 25'd0}, 1'b0, nores});
        dir.push_back('{'{CMD_ROT, 13'd5, 6'd16, 32'h8000_0000, 32'h8000_0000, 25'd0}, 1'b0, nores});
        dir.push_back('{'{CMD_ROT, 13'd260, 6'd15, 32'h0001_0000, 32'h0, 25'd0}, 1'b0, nores});
        dir.push_back('{'{CMD_ROT, 13'd260, 6'd31, 32'h0, 32'h0001_0000, 25'd0}, 1'b0, nores});
        dir.push_back('{'{CMD_ROT, 13'd77, 6'd20, 32'h7FFF_FFFF, 32'h8000_0000, 25'd0}, 1'b0, nores});
        dir.push_back('{'{CMD_ROT, 13'd140, 6'd1, 32'h1234_5678, 32'hDEAD_BEEF, 25'd0}, 1'b0, nores});
        dir.push_back('{'{CMD_ROT, 13'd33, 6'd0, 32'h0, 32'h0, 25'd0}, 1'b0, nores});
        foreach (dir[i]) send_item(dir[i].it, dir[i].typed, dir[i].res);
        wait_drained();

        cfg_set = '{'{5, 16, 16}, '{1, 1, 1}, '{16, 64, 32}, '{0, 0, 0}, '{31, 127, 63},
                    '{16, 65, 33}, '{1, 7, 32}, '{3, 63, 8}, '{8, 2, 1}, '{2, 64, 32}};
        for (int ph = 0; ph < 10; ph++) begin
            cfg_write(CFG_PREFIX, cfg_set[ph][0]);
            cfg_write(CFG_GRID, cfg_set[ph][1]);
            cfg_write(CFG_QUARTER, cfg_set[ph][2]);
            idle_en = (ph != 5);
            nitems = 115;
            for (int k = 0; k < nitems; k++) begin
                if (ph == 2 && k == 20) hold_req = 1'b1;
                if (ph == 3 && k == 50) while (pending_q.size() != 0) @(negedge i_clk);
                send_item(rand_item(), 1'b0, nores);
            end
            wait_drained();
        end
        idle_en = 1'b1;

        wait_drained();
        if (errors == 0)
            $display("axial_rope_rotation_unit_core: match");
        else
            $display("axial_rope_rotation_unit_core: mismatch");
        $finish;
    end
endmodule
